### hw/rtl/c8ic_pkg.sv
// Shared types, constants and the font table of the CHIP-8 instruction core.
// No dependencies; the top level, the sequencer and the datapath import this package.
`default_nettype none
package c8ic_pkg;

   localparam int MEM_BYTES   = 4096;
   localparam int START_ADDR  = 512;
   localparam int STACK_DEPTH = 16;
   localparam int DISP_WIDTH  = 64;
   localparam int DISP_HEIGHT = 32;

   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int STK_AW = $clog2(STACK_DEPTH);
   localparam int STK_CW = $clog2(STACK_DEPTH + 1);
   localparam int ROW_AW = $clog2(DISP_HEIGHT);
   localparam int COL_AW = $clog2(DISP_WIDTH);
   localparam int FONT_BYTES = 80;

   localparam logic [2:0] CMD_WRITE_MEM = 3'd0;
   localparam logic [2:0] CMD_EXECUTE   = 3'd1;
   localparam logic [2:0] CMD_TICK      = 3'd2;
   localparam logic [2:0] CMD_KEY       = 3'd3;
   localparam logic [2:0] CMD_READ_ROW  = 3'd4;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_OPCODE  = 3'd1;
   localparam logic [2:0] ERR_PC_RANGE    = 3'd2;
   localparam logic [2:0] ERR_STACK_OVER  = 3'd3;
   localparam logic [2:0] ERR_STACK_UNDER = 3'd4;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_FETCH1, ST_FETCH2, ST_RDY, ST_RDV0,
      ST_EXEC, ST_RET, ST_WRVF, ST_DRAW_RD, ST_DRAW_WR, ST_BCD, ST_STORE_RD,
      ST_STORE_WR, ST_LOAD_RD, ST_LOAD_WR, ST_ROW_RD, ST_OUT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_CLEAR, DP_LATCH, DP_CMD, DP_HALT_PC, DP_FETCH0, DP_FETCH1,
      DP_FETCH2, DP_RDY, DP_RDV0, DP_EXEC, DP_RET, DP_WRVF, DP_DRAW_RD,
      DP_DRAW_WR, DP_BCD, DP_STORE_RD, DP_STORE_WR, DP_LOAD_RD, DP_LOAD_WR,
      DP_ROW_RD, DP_OUT
   } dp_op_type;

   typedef enum logic [2:0] {
      NEXT_DONE, NEXT_VF, NEXT_RET, NEXT_DRAW, NEXT_BCD, NEXT_STORE, NEXT_LOAD
   } next_step_type;

   typedef struct packed {
      logic          clr_last;
      logic [2:0]    command;
      logic          running;
      logic          pc_bad;
      next_step_type next_step;
      logic          draw_last;
      logic          loop_last;
      logic          bcd_last;
      logic          rsp_full;
   } dp_status_type;

endpackage
`default_nettype wire

### hw/rtl/c8ic_req_if.sv
// Command channel of the CHIP-8 core: valid/ready handshake and one item.
// No dependencies.
`default_nettype none
interface c8ic_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [11:0] address;
   logic [7:0] data_byte;
   logic [3:0] key_number;
   logic       key_pressed;
   logic [7:0] random_byte;
   logic [4:0] row_select;

   modport source (output valid, command, address, data_byte, key_number,
                   key_pressed, random_byte, row_select, input ready);
   modport sink (input valid, command, address, data_byte, key_number,
                 key_pressed, random_byte, row_select, output ready);
endinterface
`default_nettype wire

### hw/rtl/c8ic_rsp_if.sv
// Result channel of the CHIP-8 core: valid/ready handshake and one item.
// No dependencies.
`default_nettype none
interface c8ic_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] program_counter;
   logic [63:0] row_pixels;
   logic        screen_changed;
   logic        sound_on;
   logic        waiting_for_key;
   logic [2:0]  error_code;

   modport source (output valid, program_counter, row_pixels, screen_changed,
                   sound_on, waiting_for_key, error_code, input ready);
   modport sink (input valid, program_counter, row_pixels, screen_changed,
                 sound_on, waiting_for_key, error_code, output ready);
endinterface
`default_nettype wire

### hw/rtl/chip8_instruction_core.sv
// Top level of the CHIP-8 instruction core: sequencer plus datapath.
// Depends on c8ic_pkg, c8ic_req_if, c8ic_rsp_if, c8ic_ctrl and c8ic_dpath.
//
//   channel    direction  handshake             payload
//   req_port   in         valid/ready           command, address, data, key, random, row
//   rsp_port   out        valid/ready           pc, row pixels, changed, sound, wait, error
//   csr_*      in         write enable, 1 bit   run_enable
//
// One item at a time. Non-execute commands, a stopped execute and a pc out of
// range pass dispatch, row read and output. An execute adds opcode fetch, VX
// and VY reads and execute (byte-wide memory fetch, one register read port),
// plus a VF write (8XY4-8XYE, DXYN) or a return, a read and a write per sprite
// row for DXYN, a step per digit for FX33 and a read and a write per register
// for FX55/FX65. After reset a clearing pass over all 4096 bytes loads the font
// and zeroes memory; no item is accepted meanwhile. The result sits in an output
// register: a stalled result holds the core only once the next item is finished.
`default_nettype none
module chip8_instruction_core
   import c8ic_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   c8ic_req_if.sink   req_port,
   c8ic_rsp_if.source rsp_port,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_write_data
);
   dp_status_type status;
   dp_op_type     dp_op;

   // sequencer: walks each item through dispatch, any fetch and execute steps, and result
   c8ic_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_port.valid),
      .req_ready(req_port.ready),
      .status(status),
      .dp_op(dp_op)
   );

   // datapath: machine state, memories and the result register
   c8ic_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .dp_op(dp_op),
      .status(status),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .in_command(req_port.command),
      .in_address(req_port.address),
      .in_data_byte(req_port.data_byte),
      .in_key_number(req_port.key_number),
      .in_key_pressed(req_port.key_pressed),
      .in_random_byte(req_port.random_byte),
      .in_row_select(req_port.row_select),
      .rsp_ready(rsp_port.ready),
      .rsp_valid(rsp_port.valid),
      .out_program_counter(rsp_port.program_counter),
      .out_row_pixels(rsp_port.row_pixels),
      .out_screen_changed(rsp_port.screen_changed),
      .out_sound_on(rsp_port.sound_on),
      .out_waiting_for_key(rsp_port.waiting_for_key),
      .out_error_code(rsp_port.error_code)
   );
endmodule
`default_nettype wire

### hw/rtl/c8ic_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module c8ic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### hw/rtl/c8ic_ctrl.sv
// Sequencer of the CHIP-8 core: steps the datapath through each item.
// Depends on c8ic_pkg.
`default_nettype none
module c8ic_ctrl
   import c8ic_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_op_type          dp_op
);
   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (status.clr_last) state_in = ST_IDLE;
         ST_IDLE: if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (status.command == CMD_EXECUTE && status.running && !status.pc_bad) begin
               state_in = ST_FETCH1;
            end else begin
               state_in = ST_ROW_RD;
            end
         end
         ST_FETCH1: state_in = ST_FETCH2;
         ST_FETCH2: state_in = ST_RDY;
         ST_RDY: state_in = ST_RDV0;
         ST_RDV0: state_in = ST_EXEC;
         ST_EXEC: begin
            case (status.next_step)
               NEXT_VF:    state_in = ST_WRVF;
               NEXT_RET:   state_in = ST_RET;
               NEXT_DRAW:  state_in = ST_DRAW_RD;
               NEXT_BCD:   state_in = ST_BCD;
               NEXT_STORE: state_in = ST_STORE_RD;
               NEXT_LOAD:  state_in = ST_LOAD_RD;
               default:    state_in = ST_ROW_RD;
            endcase
         end
         ST_RET: state_in = ST_ROW_RD;
         ST_WRVF: state_in = ST_ROW_RD;
         ST_DRAW_RD: state_in = ST_DRAW_WR;
         ST_DRAW_WR: state_in = status.draw_last ? ST_WRVF : ST_DRAW_RD;
         ST_BCD: if (status.bcd_last) state_in = ST_ROW_RD;
         ST_STORE_RD: state_in = ST_STORE_WR;
         ST_STORE_WR: state_in = status.loop_last ? ST_ROW_RD : ST_STORE_RD;
         ST_LOAD_RD: state_in = ST_LOAD_WR;
         ST_LOAD_WR: state_in = status.loop_last ? ST_ROW_RD : ST_LOAD_RD;
         ST_ROW_RD: state_in = ST_OUT;
         ST_OUT: if (!status.rsp_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      dp_op     = DP_NOP;
      case (state_ff)
         ST_CLEAR: dp_op = DP_CLEAR;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) dp_op = DP_LATCH;
         end
         ST_DISPATCH: begin
            if (status.command != CMD_EXECUTE) begin
               dp_op = DP_CMD;
            end else if (status.running) begin
               dp_op = status.pc_bad ? DP_HALT_PC : DP_FETCH0;
            end
         end
         ST_FETCH1:   dp_op = DP_FETCH1;
         ST_FETCH2:   dp_op = DP_FETCH2;
         ST_RDY:      dp_op = DP_RDY;
         ST_RDV0:     dp_op = DP_RDV0;
         ST_EXEC:     dp_op = DP_EXEC;
         ST_RET:      dp_op = DP_RET;
         ST_WRVF:     dp_op = DP_WRVF;
         ST_DRAW_RD:  dp_op = DP_DRAW_RD;
         ST_DRAW_WR:  dp_op = DP_DRAW_WR;
         ST_BCD:      dp_op = DP_BCD;
         ST_STORE_RD: dp_op = DP_STORE_RD;
         ST_STORE_WR: dp_op = DP_STORE_WR;
         ST_LOAD_RD:  dp_op = DP_LOAD_RD;
         ST_LOAD_WR:  dp_op = DP_LOAD_WR;
         ST_ROW_RD:   dp_op = DP_ROW_RD;
         ST_OUT:      if (!status.rsp_full) dp_op = DP_OUT;
         default:     dp_op = DP_NOP;
      endcase
   end
endmodule
`default_nettype wire

### hw/rtl/c8ic_dpath.sv
// Datapath of the CHIP-8 core: machine state, memories and result register.
// Depends on c8ic_pkg and c8ic_ram.
`default_nettype none
module c8ic_dpath
   import c8ic_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_op_type     dp_op,
   output dp_status_type      status,
   input  wire logic          csr_write_enable,
   input  wire logic          csr_write_data,
   input  wire logic [2:0]    in_command,
   input  wire logic [11:0]   in_address,
   input  wire logic [7:0]    in_data_byte,
   input  wire logic [3:0]    in_key_number,
   input  wire logic          in_key_pressed,
   input  wire logic [7:0]    in_random_byte,
   input  wire logic [4:0]    in_row_select,
   input  wire logic          rsp_ready,
   output logic               rsp_valid,
   output logic [11:0]        out_program_counter,
   output logic [63:0]        out_row_pixels,
   output logic               out_screen_changed,
   output logic               out_sound_on,
   output logic               out_waiting_for_key,
   output logic [2:0]         out_error_code
);
   logic              run_ff;
   logic [11:0]       pc_ff, idx_ff;
   logic [STK_CW-1:0] sc_ff;
   logic [7:0]        delay_ff, sound_ff;
   logic [15:0]       keys_ff;
   logic              wait_ff, halt_ff;
   logic [3:0]        wtgt_ff;
   logic [DISP_HEIGHT-1:0] fvld_ff;
   logic              rd_vld_ff;
   logic [15:0]       op_ff;
   logic [7:0]        vx_ff, vy_ff;
   logic [3:0]        cnt_ff;
   logic              flag_ff, changed_ff;
   logic [2:0]        err_ff;
   logic [MEM_AW-1:0] clr_ff;
   logic [2:0]        lc_cmd_ff;
   logic [11:0]       lc_addr_ff;
   logic [7:0]        lc_data_ff, lc_rnd_ff;
   logic [3:0]        lc_key_ff;
   logic              lc_pressed_ff;
   logic [4:0]        lc_row_ff;
   logic              rsp_valid_ff;

   // memory ports
   logic              mem_we, reg_we, stk_we, frm_we;
   logic [MEM_AW-1:0] mem_wa, mem_ra;
   logic [7:0]        mem_wd, mem_rd, reg_wd, reg_rd;
   logic [3:0]        reg_wa, reg_ra;
   logic [STK_AW-1:0] stk_wa, stk_ra;
   logic [11:0]       stk_rd;
   logic [ROW_AW-1:0] frm_wa, frm_ra;
   logic [63:0]       frm_wd, frm_rd;

   logic [3:0]  op_x, op_y, op_n;
   logic [7:0]  op_nn;
   logic [11:0] op_nnn, pc_plus2, idx_cnt;
   assign op_x   = op_ff[11:8];
   assign op_y   = op_ff[7:4];
   assign op_n   = op_ff[3:0];
   assign op_nn  = op_ff[7:0];
   assign op_nnn = op_ff[11:0];
   assign pc_plus2 = pc_ff + 12'd2;
   assign idx_cnt  = idx_ff + {8'd0, cnt_ff};

   // ALU for the 8XYN group
   logic [8:0] sum9;
   logic [7:0] alu_res;
   logic       alu_flag, alu_ok, alu_flag_wr;
   always_comb begin
      sum9 = {1'b0, vx_ff} + {1'b0, vy_ff};
      alu_res = vy_ff;
      alu_flag = 1'b0;
      alu_ok = 1'b1;
      alu_flag_wr = 1'b1;
      case (op_n)
         4'h0: begin alu_res = vy_ff;         alu_flag_wr = 1'b0; end
         4'h1: begin alu_res = vx_ff | vy_ff; alu_flag_wr = 1'b0; end
         4'h2: begin alu_res = vx_ff & vy_ff; alu_flag_wr = 1'b0; end
         4'h3: begin alu_res = vx_ff ^ vy_ff; alu_flag_wr = 1'b0; end
         4'h4: begin alu_res = sum9[7:0];     alu_flag = sum9[8]; end
         4'h5: begin alu_res = vx_ff - vy_ff; alu_flag = (vx_ff >= vy_ff); end
         4'h6: begin alu_res = {1'b0, vx_ff[7:1]}; alu_flag = vx_ff[0]; end
         4'h7: begin alu_res = vy_ff - vx_ff; alu_flag = (vy_ff >= vx_ff); end
         4'hE: begin alu_res = {vx_ff[6:0], 1'b0}; alu_flag = vx_ff[7]; end
         default: begin alu_ok = 1'b0; alu_flag_wr = 1'b0; end
      endcase
   end

   // decimal digits of VX for FX33
   logic [7:0]  rem8;
   logic [1:0]  hund;
   logic [14:0] tmul;
   logic [3:0]  tens;
   logic [7:0]  ones, digit;
   always_comb begin
      if (vx_ff >= 8'd200) begin
         hund = 2'd2; rem8 = vx_ff - 8'd200;
      end else if (vx_ff >= 8'd100) begin
         hund = 2'd1; rem8 = vx_ff - 8'd100;
      end else begin
         hund = 2'd0; rem8 = vx_ff;
      end
      tmul = {8'd0, rem8[6:0]} * 15'd205;
      tens = tmul[14:11];
      ones = rem8 - 8'({tens, 3'd0} + {tens, 1'b0});
      case (cnt_ff[1:0])
         2'd0:    digit = {6'd0, hund};
         2'd1:    digit = {4'd0, tens};
         default: digit = ones;
      endcase
   end

   // execute decode: error, follow-up step, single register write
   logic [2:0]    ex_err;
   next_step_type ex_step;
   logic          ex_reg_we;
   logic [7:0]    ex_reg_wd;
   logic          stk_full, key_hit;
   assign stk_full = (sc_ff >= STK_CW'(STACK_DEPTH));
   assign key_hit  = keys_ff[vx_ff[3:0]] && (vx_ff < 8'd16);
   always_comb begin
      ex_err = ERR_NONE;
      ex_step = NEXT_DONE;
      ex_reg_we = 1'b0;
      ex_reg_wd = op_nn;
      case (op_ff[15:12])
         4'h0: begin
            if (op_ff == 16'h00EE) begin
               if (sc_ff == '0) ex_err = ERR_STACK_UNDER;
               else ex_step = NEXT_RET;
            end else if (op_ff != 16'h00E0) begin
               ex_err = ERR_BAD_OPCODE;
            end
         end
         4'h2: if (stk_full) ex_err = ERR_STACK_OVER;
         4'h6: ex_reg_we = 1'b1;
         4'h7: begin ex_reg_we = 1'b1; ex_reg_wd = vx_ff + op_nn; end
         4'h8: begin
            if (alu_ok) begin
               ex_reg_we = 1'b1;
               ex_reg_wd = alu_res;
               if (alu_flag_wr) ex_step = NEXT_VF;
            end else begin
               ex_err = ERR_BAD_OPCODE;
            end
         end
         4'hC: begin ex_reg_we = 1'b1; ex_reg_wd = lc_rnd_ff & op_nn; end
         4'hD: ex_step = (op_n == 4'd0) ? NEXT_VF : NEXT_DRAW;
         4'hE: if (op_nn != 8'h9E && op_nn != 8'hA1) ex_err = ERR_BAD_OPCODE;
         4'hF: begin
            case (op_nn)
               8'h07: begin ex_reg_we = 1'b1; ex_reg_wd = delay_ff; end
               8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29: ex_step = NEXT_DONE;
               8'h33: ex_step = NEXT_BCD;
               8'h55: ex_step = NEXT_STORE;
               8'h65: ex_step = NEXT_LOAD;
               default: ex_err = ERR_BAD_OPCODE;
            endcase
         end
         default: ex_step = NEXT_DONE;
      endcase
   end

   // sprite line against the current display row
   logic [ROW_AW-1:0] draw_row;
   logic [63:0]       line, line_rot, cur_row;
   logic [127:0]      line_dbl;
   logic              hit;
   assign draw_row = ROW_AW'(vy_ff[ROW_AW-1:0] + {1'b0, cnt_ff});
   assign line     = {mem_rd, 56'd0};
   assign line_dbl = {line, line} >> vx_ff[COL_AW-1:0];
   assign line_rot = line_dbl[63:0];
   assign cur_row  = rd_vld_ff ? frm_rd : 64'd0;
   assign hit      = |(cur_row & line_rot);

   // memory port selection
   always_comb begin
      mem_we = 1'b0; mem_wa = lc_addr_ff; mem_wd = lc_data_ff;
      reg_we = 1'b0; reg_wa = op_x;       reg_wd = ex_reg_wd;
      stk_we = 1'b0; stk_wa = sc_ff[STK_AW-1:0];
      frm_we = 1'b0; frm_wa = draw_row;   frm_wd = cur_row ^ line_rot;
      mem_ra = pc_ff;
      reg_ra = 4'd0;
      frm_ra = lc_row_ff;
      stk_ra = STK_AW'(sc_ff - 1'b1);
      case (dp_op)
         DP_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = (clr_ff < MEM_AW'(FONT_BYTES)) ? FONT_ROM[clr_ff[6:0]] : 8'd0;
            reg_we = (clr_ff < MEM_AW'(16));
            reg_wa = clr_ff[3:0];
            reg_wd = 8'd0;
         end
         DP_CMD: begin
            mem_we = (lc_cmd_ff == CMD_WRITE_MEM);
            reg_we = (lc_cmd_ff == CMD_KEY) && wait_ff && lc_pressed_ff;
            reg_wa = wtgt_ff;
            reg_wd = {4'd0, lc_key_ff};
         end
         DP_FETCH1: mem_ra = pc_ff + 12'd1;
         DP_FETCH2: reg_ra = op_x;
         DP_RDY:    reg_ra = op_y;
         DP_EXEC: begin
            reg_we = ex_reg_we;
            stk_we = (op_ff[15:12] == 4'h2) && !stk_full;
         end
         DP_WRVF: begin
            reg_we = 1'b1; reg_wa = 4'hF; reg_wd = {7'd0, flag_ff};
         end
         DP_DRAW_RD: begin mem_ra = idx_cnt; frm_ra = draw_row; end
         DP_DRAW_WR: frm_we = 1'b1;
         DP_BCD: begin mem_we = 1'b1; mem_wa = idx_cnt; mem_wd = digit; end
         DP_STORE_RD: reg_ra = cnt_ff;
         DP_STORE_WR: begin mem_we = 1'b1; mem_wa = idx_cnt; mem_wd = reg_rd; end
         DP_LOAD_RD: mem_ra = idx_cnt;
         DP_LOAD_WR: begin reg_we = 1'b1; reg_wa = cnt_ff; reg_wd = mem_rd; end
         default: mem_ra = pc_ff;
      endcase
   end

   c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd));
   c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
      .clock(clock), .wr_en(reg_we), .wr_addr(reg_wa), .wr_data(reg_wd),
      .rd_addr(reg_ra), .rd_data(reg_rd));
   c8ic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(pc_ff),
      .rd_addr(stk_ra), .rd_data(stk_rd));
   c8ic_ram #(.WIDTH(64), .DEPTH(DISP_HEIGHT)) u_frame (
      .clock(clock), .wr_en(frm_we), .wr_addr(frm_wa), .wr_data(frm_wd),
      .rd_addr(frm_ra), .rd_data(frm_rd));

   // machine state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b1;
         pc_ff <= 12'(START_ADDR);
         idx_ff <= '0;
         sc_ff <= '0;
         delay_ff <= '0;
         sound_ff <= '0;
         keys_ff <= '0;
         wait_ff <= 1'b0;
         wtgt_ff <= '0;
         halt_ff <= 1'b0;
         fvld_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) run_ff <= csr_write_data;
         if (dp_op == DP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (dp_op)
            DP_CLEAR: clr_ff <= clr_ff + 1'b1;
            DP_CMD: begin
               case (lc_cmd_ff)
                  CMD_TICK: begin
                     if (delay_ff != 8'd0) delay_ff <= delay_ff - 8'd1;
                     if (sound_ff != 8'd0) sound_ff <= sound_ff - 8'd1;
                  end
                  CMD_KEY: begin
                     keys_ff[lc_key_ff] <= lc_pressed_ff;
                     if (wait_ff && lc_pressed_ff) wait_ff <= 1'b0;
                  end
                  default: ;
               endcase
            end
            DP_HALT_PC: halt_ff <= 1'b1;
            DP_FETCH2: pc_ff <= pc_plus2;
            DP_EXEC: begin
               if (ex_err != ERR_NONE) halt_ff <= 1'b1;
               case (op_ff[15:12])
                  4'h0: begin
                     if (op_ff == 16'h00E0) fvld_ff <= '0;
                     if (op_ff == 16'h00EE && sc_ff != '0) sc_ff <= sc_ff - 1'b1;
                  end
                  4'h1: pc_ff <= op_nnn;
                  4'h2: if (!stk_full) begin sc_ff <= sc_ff + 1'b1; pc_ff <= op_nnn; end
                  4'h3: if (vx_ff == op_nn) pc_ff <= pc_plus2;
                  4'h4: if (vx_ff != op_nn) pc_ff <= pc_plus2;
                  4'h5: if (vx_ff == vy_ff) pc_ff <= pc_plus2;
                  4'h9: if (vx_ff != vy_ff) pc_ff <= pc_plus2;
                  4'hA: idx_ff <= op_nnn;
                  4'hB: pc_ff <= op_nnn + {4'd0, reg_rd};
                  4'hE: begin
                     if (op_nn == 8'h9E && key_hit) begin
                        pc_ff <= pc_plus2;
                        keys_ff[vx_ff[3:0]] <= 1'b0;
                     end
                     if (op_nn == 8'hA1 && !key_hit) pc_ff <= pc_plus2;
                  end
                  4'hF: begin
                     case (op_nn)
                        8'h0A: begin wait_ff <= 1'b1; wtgt_ff <= op_x; end
                        8'h15: delay_ff <= vx_ff;
                        8'h18: sound_ff <= vx_ff;
                        8'h1E: idx_ff <= idx_ff + {4'd0, vx_ff};
                        8'h29: idx_ff <= {2'd0, vx_ff, 2'd0} + {4'd0, vx_ff};
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
            DP_RET: pc_ff <= stk_rd;
            DP_DRAW_WR: fvld_ff[draw_row] <= 1'b1;
            default: ;
         endcase
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      case (dp_op)
         DP_LATCH: begin
            lc_cmd_ff <= in_command;
            lc_addr_ff <= in_address;
            lc_data_ff <= in_data_byte;
            lc_key_ff <= in_key_number;
            lc_pressed_ff <= in_key_pressed;
            lc_rnd_ff <= in_random_byte;
            lc_row_ff <= in_row_select;
            changed_ff <= 1'b0;
            err_ff <= ERR_NONE;
         end
         DP_HALT_PC: err_ff <= ERR_PC_RANGE;
         DP_FETCH1: op_ff[15:8] <= mem_rd;
         DP_FETCH2: op_ff[7:0] <= mem_rd;
         DP_RDY: vx_ff <= reg_rd;
         DP_RDV0: vy_ff <= reg_rd;
         DP_EXEC: begin
            err_ff <= ex_err;
            cnt_ff <= 4'd0;
            flag_ff <= (op_ff[15:12] == 4'h8) ? alu_flag : 1'b0;
            if (op_ff == 16'h00E0 || op_ff[15:12] == 4'hD) changed_ff <= 1'b1;
         end
         DP_DRAW_RD: rd_vld_ff <= fvld_ff[draw_row];
         DP_DRAW_WR: begin
            flag_ff <= flag_ff | hit;
            cnt_ff <= cnt_ff + 4'd1;
         end
         DP_BCD, DP_STORE_WR, DP_LOAD_WR: cnt_ff <= cnt_ff + 4'd1;
         DP_ROW_RD: rd_vld_ff <= fvld_ff[lc_row_ff];
         DP_OUT: begin
            out_program_counter <= pc_ff;
            out_row_pixels <= cur_row;
            out_screen_changed <= changed_ff;
            out_sound_on <= (sound_ff != 8'd0);
            out_waiting_for_key <= wait_ff;
            out_error_code <= err_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   assign status.clr_last  = (clr_ff == MEM_AW'(MEM_BYTES - 1));
   assign status.command   = lc_cmd_ff;
   assign status.running   = run_ff && !wait_ff && !halt_ff;
   assign status.pc_bad    = (pc_ff > 12'(MEM_BYTES - 2));
   assign status.next_step = (ex_err != ERR_NONE) ? NEXT_DONE : ex_step;
   assign status.draw_last = (cnt_ff == op_n - 4'd1);
   assign status.loop_last = (cnt_ff == op_x);
   assign status.bcd_last  = (cnt_ff == 4'd2);
   assign status.rsp_full  = rsp_valid_ff && !rsp_ready;
endmodule
`default_nettype wire
